// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the deframer rtl
// no dependencies; simulation keeps the checks, synthesis sees empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge out of reset
`define TDFS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");

// consequent holds in the same cycle as the antecedent
`define TDFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// consequent holds in the cycle after the antecedent
`define TDFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define TDFS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define TDFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TDFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/tdfs_pkg.sv -----
// shared types and constants of the typed frame deframer
// no dependencies
package tdfs_pkg;

    localparam int HEADER_W       = 16;
    localparam int TABLE_W        = 48;
    localparam int CFG_DATA_W     = 48;
    localparam int CFG_INDEX_W    = 2;
    localparam int NUM_TYPES      = 6;
    localparam int MIN_FRAME_HELD = 5;
    localparam int MAX_RESULTS    = 32;
    localparam int RESULT_CNT_W   = 6;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_ID  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_LEN = 2'd2;

    localparam logic [HEADER_W-1:0] HEADER_RESET   = 16'd0;
    localparam logic [TABLE_W-1:0]  TYPE_ID_RESET  = 48'd19860213989376;
    localparam logic [TABLE_W-1:0]  TYPE_LEN_RESET = 48'd5566362029594;

    typedef struct packed {
        logic [HEADER_W-1:0] header_value;
        logic [TABLE_W-1:0]  type_id_table;
        logic [TABLE_W-1:0]  type_length_table;
    } cfg_t;

endpackage

// ----- rtl/core/tdfs_buffer_ram.sv -----
// frame buffer storage: one write port, one read port with registered data
// no dependencies
module tdfs_buffer_ram #(
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/tdfs_parser.sv -----
// buffer sequencer: append, header scan, type lookup, checksum and payload play-out
// depends on tdfs_pkg and assert_macros.svh; drives the ports of tdfs_buffer_ram
`include "assert_macros.svh"

module tdfs_parser
    import tdfs_pkg::*;
#(
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int CNT_W = ADDR_W + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        frame_type,
    output logic [7:0]        payload_byte,
    output logic [4:0]        byte_index,
    output logic              is_last,
    output logic              ram_wr_en,
    output logic [ADDR_W-1:0] ram_wr_addr,
    output logic [7:0]        ram_wr_data,
    output logic              ram_rd_en,
    output logic [ADDR_W-1:0] ram_rd_addr,
    input  logic [7:0]        ram_rd_data
);

    localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] MIN_HELD_C = CNT_W'(MIN_FRAME_HELD);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_TYPE_RD,
        ST_TYPE_CHK,
        ST_LEN_CHK,
        ST_SUM,
        ST_FINISH,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
        logic [7:0] len;
    } type_hit_t;

    // circular offset from the buffer head
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W-1:0] s;
        s = CNT_W'(base) + off;
        if (s >= DEPTH_C)
        begin
            s = s - DEPTH_C;
        end
        return s[ADDR_W-1:0];
    endfunction

    // lowest matching entry wins
    function automatic type_hit_t lookup_type(input logic [7:0] id,
                                              input logic [TABLE_W-1:0] ids,
                                              input logic [TABLE_W-1:0] lens);
        type_hit_t r;
        r = '0;
        for (int t = NUM_TYPES - 1; t >= 0; t--)
        begin
            if (ids[8*t +: 8] == id)
            begin
                r.hit = 1'b1;
                r.idx = 3'(t);
                r.len = lens[8*t +: 8];
            end
        end
        return r;
    endfunction

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        off_reg, off_next;
    logic [7:0]              prev_reg, prev_next;
    logic [7:0]              sum_reg, sum_next;
    logic                    hit_reg, hit_next;
    logic [2:0]              type_reg, type_next;
    logic [CNT_W-1:0]        len_reg, len_next;
    logic                    good_reg, good_next;
    logic [ADDR_W-1:0]       good_start_reg, good_start_next;
    logic [2:0]              good_type_reg, good_type_next;
    logic [RESULT_CNT_W-1:0] good_n_reg, good_n_next;
    logic [RESULT_CNT_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0]       emit_ptr_reg, emit_ptr_next;
    logic                    out_valid_reg, out_valid_next;
    logic [2:0]              frame_type_reg, frame_type_next;
    logic [7:0]              payload_byte_reg, payload_byte_next;
    logic [4:0]              byte_index_reg, byte_index_next;
    logic                    is_last_reg, is_last_next;

    type_hit_t               lk;
    logic [CNT_W-1:0]        len_eff;
    logic [7:0]              n_full;
    logic [RESULT_CNT_W-1:0] n_clip;
    logic                    pair_hit;
    logic                    emit_last;
    logic                    drop_all;
    logic [ADDR_W-1:0]       drop_head;
    logic [CNT_W-1:0]        drop_fill;

    always_comb
    begin
        lk = lookup_type(ram_rd_data, cfg.type_id_table, cfg.type_length_table);
        // long lengths saturate to the depth, zero counts as one
        if (lk.len > 8'(DEPTH))
        begin
            len_eff = DEPTH_C;
        end
        else if (lk.len == 8'd0)
        begin
            len_eff = CNT_W'(1);
        end
        else
        begin
            len_eff = CNT_W'(lk.len);
        end
        n_full    = 8'(len_reg) - 8'd4;
        n_clip    = (n_full > 8'(MAX_RESULTS)) ? RESULT_CNT_W'(MAX_RESULTS)
                                               : n_full[RESULT_CNT_W-1:0];
        pair_hit  = (off_reg != CNT_W'(1)) && (prev_reg == cfg.header_value[15:8])
                    && (ram_rd_data == cfg.header_value[7:0]);
        emit_last = (RESULT_CNT_W'(k_reg + 1'b1) == good_n_reg);
        drop_all  = (len_reg >= fill_reg);
        drop_head = wrap_add(head_reg, len_reg);
        drop_fill = fill_reg - len_reg;
    end

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        fill_next         = fill_reg;
        off_next          = off_reg;
        prev_next         = prev_reg;
        sum_next          = sum_reg;
        hit_next          = hit_reg;
        type_next         = type_reg;
        len_next          = len_reg;
        good_next         = good_reg;
        good_start_next   = good_start_reg;
        good_type_next    = good_type_reg;
        good_n_next       = good_n_reg;
        k_next            = k_reg;
        emit_ptr_next     = emit_ptr_reg;
        out_valid_next    = out_valid_reg && out_stall;
        frame_type_next   = frame_type_reg;
        payload_byte_next = payload_byte_reg;
        byte_index_next   = byte_index_reg;
        is_last_next      = is_last_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = wrap_add(head_reg, fill_reg);
        ram_wr_data       = rx_byte;
        ram_rd_en         = 1'b0;
        ram_rd_addr       = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    good_next = 1'b0;
                    if (fill_reg < DEPTH_C)
                    begin
                        ram_wr_en = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (fill_reg >= MIN_HELD_C)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = head_reg;
                    off_next    = CNT_W'(1);
                    state_next  = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (pair_hit)
                begin
                    head_next  = wrap_add(head_reg, off_reg - CNT_W'(2));
                    fill_next  = fill_reg - (off_reg - CNT_W'(2));
                    state_next = ST_TYPE_RD;
                end
                else if (off_reg == fill_reg)
                begin
                    fill_next  = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = wrap_add(head_reg, off_reg);
                    off_next    = off_reg + 1'b1;
                    prev_next   = ram_rd_data;
                end
            end
            ST_TYPE_RD:
            begin
                if (fill_reg < CNT_W'(3))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = wrap_add(head_reg, CNT_W'(2));
                    state_next  = ST_TYPE_CHK;
                end
            end
            ST_TYPE_CHK:
            begin
                hit_next   = lk.hit;
                type_next  = lk.idx;
                len_next   = len_eff;
                state_next = ST_LEN_CHK;
            end
            ST_LEN_CHK:
            begin
                if (!hit_reg)
                begin
                    head_next  = wrap_add(head_reg, CNT_W'(1));
                    fill_next  = fill_reg - 1'b1;
                    state_next = ST_CHECK;
                end
                else if (fill_reg < len_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (len_reg >= CNT_W'(3))
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = head_reg;
                    off_next    = CNT_W'(1);
                    sum_next    = '0;
                    state_next  = ST_SUM;
                end
                else
                begin
                    head_next  = drop_all ? head_reg : drop_head;
                    fill_next  = drop_all ? '0 : drop_fill;
                    state_next = ST_CHECK;
                end
            end
            ST_SUM:
            begin
                if (off_reg != len_reg)
                begin
                    sum_next    = sum_reg + ram_rd_data;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = wrap_add(head_reg, off_reg);
                    off_next    = off_reg + 1'b1;
                end
                else
                begin
                    // a later good frame in the same pass replaces an earlier one
                    if ((sum_reg == ram_rd_data) && (len_reg >= MIN_HELD_C))
                    begin
                        good_next       = 1'b1;
                        good_start_next = head_reg;
                        good_type_next  = type_reg;
                        good_n_next     = n_clip;
                    end
                    head_next  = drop_all ? head_reg : drop_head;
                    fill_next  = drop_all ? '0 : drop_fill;
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (good_reg)
                begin
                    k_next        = '0;
                    emit_ptr_next = wrap_add(good_start_reg, CNT_W'(3));
                    state_next    = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                ram_rd_en     = 1'b1;
                ram_rd_addr   = emit_ptr_reg;
                emit_ptr_next = wrap_add(emit_ptr_reg, CNT_W'(1));
                state_next    = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    frame_type_next   = good_type_reg;
                    payload_byte_next = ram_rd_data;
                    byte_index_next   = k_reg[4:0];
                    is_last_next      = emit_last;
                    k_next            = k_reg + 1'b1;
                    if (emit_last)
                    begin
                        good_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            head_reg         <= '0;
            fill_reg         <= '0;
            off_reg          <= '0;
            prev_reg         <= '0;
            sum_reg          <= '0;
            hit_reg          <= 1'b0;
            type_reg         <= '0;
            len_reg          <= '0;
            good_reg         <= 1'b0;
            good_start_reg   <= '0;
            good_type_reg    <= '0;
            good_n_reg       <= '0;
            k_reg            <= '0;
            emit_ptr_reg     <= '0;
            out_valid_reg    <= 1'b0;
            frame_type_reg   <= '0;
            payload_byte_reg <= '0;
            byte_index_reg   <= '0;
            is_last_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            fill_reg         <= fill_next;
            off_reg          <= off_next;
            prev_reg         <= prev_next;
            sum_reg          <= sum_next;
            hit_reg          <= hit_next;
            type_reg         <= type_next;
            len_reg          <= len_next;
            good_reg         <= good_next;
            good_start_reg   <= good_start_next;
            good_type_reg    <= good_type_next;
            good_n_reg       <= good_n_next;
            k_reg            <= k_next;
            emit_ptr_reg     <= emit_ptr_next;
            out_valid_reg    <= out_valid_next;
            frame_type_reg   <= frame_type_next;
            payload_byte_reg <= payload_byte_next;
            byte_index_reg   <= byte_index_next;
            is_last_reg      <= is_last_next;
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign frame_type   = frame_type_reg;
    assign payload_byte = payload_byte_reg;
    assign byte_index   = byte_index_reg;
    assign is_last      = is_last_reg;

    `TDFS_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= DEPTH_C)
    `TDFS_ASSERT_ALWAYS(a_head_bound, clk, rst_n, CNT_W'(head_reg) < DEPTH_C)
    `TDFS_ASSERT_IMPLY(a_pass_end_not_full, clk, rst_n, state_reg == ST_FINISH, fill_reg < DEPTH_C)
    `TDFS_ASSERT_IMPLY(a_emit_count, clk, rst_n, (state_reg == ST_EMIT_RD) || (state_reg == ST_EMIT_LD), (good_n_reg != '0) && (k_reg < good_n_reg))
    `TDFS_ASSERT_NEXT(a_append, clk, rst_n, in_valid && !in_stall, (state_reg == ST_CHECK) && ((fill_reg == $past(fill_reg) + 1'b1) || (fill_reg == DEPTH_C)))

endmodule

// ----- rtl/core/typed_frame_deframer_sum8_unit.sv -----
// top level of the typed frame deframer with 8-bit sum checksum
// depends on tdfs_pkg, tdfs_buffer_ram and tdfs_parser
//
// usage
// - input channel: one received byte per word on rx_byte, in_valid / in_stall
// - output channel: one payload byte per word with frame_type, byte_index and
//   is_last, out_valid / out_stall; is_last marks the final word of a frame
// - configuration: cfg_write with cfg_index and cfg_data, one write per edge,
//   only while the block is idle; unknown indexes are ignored
// - sequence: a new byte is taken only while the block is idle; while fewer
//   than five bytes are held a byte goes from idle to check to finish; beyond
//   that each pass of the parser starts with a check, scans bytes up to and
//   including the header pair, reads the type byte, checks it against the table,
//   checks the length and sums each frame byte, all on the single read port of the buffer ram
// - play-out: after a pass ends with a good frame, each word is read from the
//   buffer ram, then loaded into the output register unless the receiver stalls
// - reset: buffer empty, registers back to their defaults, output idle; the
//   ram contents are not cleared since only held bytes are ever read
// - stall: a stalled word stays in the output register and play-out pauses;
//   after the last word of a frame the block takes bytes again even while
//   that word still waits
module typed_frame_deframer_sum8_unit
    import tdfs_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             frame_type,
    output logic [7:0]             payload_byte,
    output logic [4:0]             byte_index,
    output logic                   is_last
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    // configuration registers
    logic [HEADER_W-1:0] header_reg;
    logic [TABLE_W-1:0]  type_id_reg;
    logic [TABLE_W-1:0]  type_len_reg;
    cfg_t                cfg;

    // buffer ram port
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg   <= HEADER_RESET;
            type_id_reg  <= TYPE_ID_RESET;
            type_len_reg <= TYPE_LEN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HEADER:   header_reg   <= cfg_data[HEADER_W-1:0];
                REG_TYPE_ID:  type_id_reg  <= cfg_data[TABLE_W-1:0];
                REG_TYPE_LEN: type_len_reg <= cfg_data[TABLE_W-1:0];
                default:      ; // unused index, write dropped
            endcase
        end
    end

    // header high byte is the first one on the wire
    assign cfg.header_value      = header_reg;
    assign cfg.type_id_table     = type_id_reg;
    assign cfg.type_length_table = type_len_reg;

    tdfs_buffer_ram #(
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    tdfs_parser #(
        .DEPTH (BUFFER_DEPTH)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_type   (frame_type),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .is_last      (is_last),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

endmodule
